// ===== src/cst_pkg.sv =====
// shared types, codes and constants of the call syntax tokenizer
// no dependencies; used by every other file of the block
package cst_pkg;

   // default sizes
   localparam int LINE_MAX_DEF = 256;
   localparam int MAX_ARGS_DEF = 8;
   localparam int QUEUE_DEPTH  = 2;

   // special characters
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // character classes
   localparam logic [2:0] CC_OTHER   = 3'd0;
   localparam logic [2:0] CC_ZERO    = 3'd1;
   localparam logic [2:0] CC_SPACE   = 3'd2;
   localparam logic [2:0] CC_LETTER  = 3'd3;
   localparam logic [2:0] CC_OPEN    = 3'd4;
   localparam logic [2:0] CC_CLOSE   = 3'd5;
   localparam logic [2:0] CC_COMMA   = 3'd6;
   localparam logic [2:0] CC_ILLEGAL = 3'd7;

   // scanner states
   localparam logic [2:0] ST_DRAIN = 3'd0;
   localparam logic [2:0] ST_LEAD  = 3'd1;
   localparam logic [2:0] ST_NAME  = 3'd2;
   localparam logic [2:0] ST_GAP   = 3'd3;
   localparam logic [2:0] ST_OPEN  = 3'd4;
   localparam logic [2:0] ST_ARG   = 3'd5;
   localparam logic [2:0] ST_TRAIL = 3'd6;

   // byte roles
   localparam logic [1:0] ROLE_SKIP = 2'd0;
   localparam logic [1:0] ROLE_NAME = 2'd1;
   localparam logic [1:0] ROLE_ARG  = 2'd2;
   localparam logic [1:0] ROLE_SEP  = 2'd3;

   // parse status codes
   localparam logic [2:0] PS_OK          = 3'd0;
   localparam logic [2:0] PS_EMPTY       = 3'd1;
   localparam logic [2:0] PS_ILLEGAL     = 3'd2;
   localparam logic [2:0] PS_TOO_LONG    = 3'd3;
   localparam logic [2:0] PS_EMPTY_ARG   = 3'd4;
   localparam logic [2:0] PS_TOO_MANY    = 3'd5;
   localparam logic [2:0] PS_NO_CLOSE    = 3'd6;
   localparam logic [2:0] PS_INNER_SPACE = 3'd7;

   // head of the class queue as seen by the scanner
   typedef struct packed {
      logic       valid;
      logic [2:0] char_class;
   } cls_q_type;

   // one result item
   typedef struct packed {
      logic [1:0] byte_role;
      logic [2:0] arg_number;
      logic       line_done;
      logic [2:0] parse_status;
      logic [3:0] args_found;
   } rsp_item_type;

   // sort a byte into its class
   function automatic logic [2:0] classify(input logic [7:0] b);
      logic [2:0] c;
      c = CC_OTHER;
      if (b[7]) begin
         c = CC_ILLEGAL;
      end else begin
         case (b) inside
            CH_NUL:                      c = CC_ZERO;
            [CH_TAB:CH_CR], CH_SPACE:    c = CC_SPACE;
            [CH_LOW_A:CH_LOW_Z], CH_UNDER: c = CC_LETTER;
            CH_OPEN:                     c = CC_OPEN;
            CH_CLOSE:                    c = CC_CLOSE;
            CH_COMMA:                    c = CC_COMMA;
            default:                     c = CC_OTHER;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== src/call_syntax_tokenizer_unit.sv =====
// A pushed byte is classified and its class code registered in the class queue; the scanner
// turns the queue head into a result item in the result queue, shown on the rsp_ ports.
// Throughput: one byte per cycle while the result queue has room, set by the scanner state
// register closing its loop; both sides run decoupled through two-entry register queues.
// Reset (synchronous): both queues empty, scanner at the start of a new line; no
// clearing pass, items are taken right after reset is released.
// Top level; depends on cst_pkg, cst_front, cst_back and cst_fifo.
module call_syntax_tokenizer_unit #(
   parameter int LINE_MAX = cst_pkg::LINE_MAX_DEF,
   parameter int MAX_ARGS = cst_pkg::MAX_ARGS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_line_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_byte_role,
   output logic [2:0] rsp_arg_number,
   output logic       rsp_line_done,
   output logic [2:0] rsp_parse_status,
   output logic [3:0] rsp_args_found
);

   localparam int RSP_W = $bits(cst_pkg::rsp_item_type);

   cst_pkg::cls_q_type    cls_q;
   logic                  cls_pop;
   logic                  rsp_q_full;
   logic                  rsp_q_push;
   cst_pkg::rsp_item_type rsp_item;
   cst_pkg::rsp_item_type rsp_head;
   logic [RSP_W-1:0]      rsp_rdata;

   // classify and queue
   cst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_line_byte (req_line_byte),
      .cls_q         (cls_q),
      .cls_pop       (cls_pop)
   );

   // scanner
   cst_back #(
      .LINE_MAX (LINE_MAX),
      .MAX_ARGS (MAX_ARGS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cls_q    (cls_q),
      .cls_pop  (cls_pop),
      .rsp_full (rsp_q_full),
      .rsp_push (rsp_q_push),
      .rsp_item (rsp_item)
   );

   // result queue
   cst_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (cst_pkg::QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_q_push),
      .wdata (rsp_item),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_head         = cst_pkg::rsp_item_type'(rsp_rdata);
   assign rsp_byte_role    = rsp_head.byte_role;
   assign rsp_arg_number   = rsp_head.arg_number;
   assign rsp_line_done    = rsp_head.line_done;
   assign rsp_parse_status = rsp_head.parse_status;
   assign rsp_args_found   = rsp_head.args_found;

   // scanner never writes into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_q_push |-> !rsp_q_full)
      else $error("result queue written while full");

   // status and count stay zero on bytes that do not finish a line
   a_quiet_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_q_push && !rsp_item.line_done) |->
         (rsp_item.parse_status == cst_pkg::PS_OK && rsp_item.args_found == 4'd0))
      else $error("status or count on a byte that does not finish the line");

   // any error reports a skipped byte and no arguments
   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_q_push && rsp_item.parse_status != cst_pkg::PS_OK) |->
         (rsp_item.byte_role == cst_pkg::ROLE_SKIP && rsp_item.args_found == 4'd0
          && rsp_item.arg_number == 3'd0 && rsp_item.line_done))
      else $error("error item carries a role or a count");

endmodule

// ===== src/cst_fifo.sv =====
// small first-in first-out queue built from registers
// depends on cst_pkg for its default depth
module cst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cst_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/cst_front.sv =====
// front end: takes line bytes, classifies them and queues the class codes
// depends on cst_pkg and cst_fifo
module cst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_line_byte,
   output cst_pkg::cls_q_type cls_q,
   input  logic              cls_pop
);

   logic [2:0] char_class;
   logic [2:0] head_class;
   logic       q_empty;

   // byte classification ahead of the queue
   assign char_class = cst_pkg::classify(req_line_byte);

   cst_fifo #(
      .WIDTH (3),
      .DEPTH (cst_pkg::QUEUE_DEPTH)
   ) u_cls_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (char_class),
      .full  (req_full),
      .pop   (cls_pop),
      .rdata (head_class),
      .empty (q_empty)
   );

   // queue head toward the scanner
   assign cls_q.valid      = !q_empty;
   assign cls_q.char_class = head_class;

endmodule

// ===== src/cst_back.sv =====
// back end: line scanner that turns class codes into result items
// depends on cst_pkg
module cst_back #(
   parameter int LINE_MAX = cst_pkg::LINE_MAX_DEF,
   parameter int MAX_ARGS = cst_pkg::MAX_ARGS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cst_pkg::cls_q_type     cls_q,
   output logic                   cls_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output cst_pkg::rsp_item_type  rsp_item
);

   localparam int POS_W = $clog2(LINE_MAX + 1);
   localparam int CNT_W = $clog2(MAX_ARGS + 1);

   logic [2:0]       state_ff, state_in;
   logic             has_text_ff, has_text_in;
   logic [CNT_W-1:0] arg_cnt_ff, arg_cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             line_start_ff, line_start_in;

   logic [2:0]       cc;
   logic             is_zero, is_space, is_letter;
   logic [CNT_W-1:0] cnt_plus;
   logic [CNT_W+3:0] cnt_ext, found_ext;
   logic             open_go, comma_go, fin, new_line, argn_sel;
   logic [2:0]       err;

   // handshake: one class code per cycle while the result queue has room
   assign cls_pop  = cls_q.valid && !rsp_full;
   assign rsp_push = cls_pop;

   assign cc        = cls_q.char_class;
   assign is_zero   = (cc == cst_pkg::CC_ZERO);
   assign is_space  = (cc == cst_pkg::CC_SPACE);
   assign is_letter = (cc == cst_pkg::CC_LETTER);
   assign cnt_plus  = arg_cnt_ff + CNT_W'(1);
   assign cnt_ext   = {4'b0000, arg_cnt_ff};
   assign found_ext = {4'b0000, arg_cnt_in};

   // scanner transition, including the fall-through of the early states
   always_comb begin
      state_in      = state_ff;
      has_text_in   = has_text_ff;
      arg_cnt_in    = arg_cnt_ff;
      pos_in        = pos_ff;
      line_start_in = line_start_ff;
      open_go       = 1'b0;
      comma_go      = 1'b0;
      fin           = 1'b0;
      new_line      = 1'b0;
      argn_sel      = 1'b0;
      err           = cst_pkg::PS_OK;
      rsp_item      = '0;

      if (state_ff == cst_pkg::ST_DRAIN) begin
         // ignore bytes until the terminator
         new_line = is_zero;
      end else if (line_start_ff && is_zero) begin
         rsp_item.line_done    = 1'b1;
         rsp_item.parse_status = cst_pkg::PS_EMPTY;
         new_line              = 1'b1;
      end else begin
         if (cc == cst_pkg::CC_ILLEGAL) begin
            err = cst_pkg::PS_ILLEGAL;
         end else if (pos_ff >= POS_W'(LINE_MAX)) begin
            err = cst_pkg::PS_TOO_LONG;
         end else begin
            case (state_ff)
               cst_pkg::ST_LEAD: begin
                  if (is_letter) begin
                     rsp_item.byte_role = cst_pkg::ROLE_NAME;
                     state_in           = cst_pkg::ST_NAME;
                  end else if (!is_space) begin
                     open_go = 1'b1;
                  end
               end
               cst_pkg::ST_NAME: begin
                  if (is_letter) begin
                     rsp_item.byte_role = cst_pkg::ROLE_NAME;
                  end else if (is_space) begin
                     state_in = cst_pkg::ST_GAP;
                  end else begin
                     open_go = 1'b1;
                  end
               end
               cst_pkg::ST_GAP: begin
                  open_go = !is_space;
               end
               cst_pkg::ST_OPEN: begin
                  open_go = 1'b1;
               end
               cst_pkg::ST_ARG: begin
                  if (is_zero) begin
                     err = cst_pkg::PS_NO_CLOSE;
                  end else if (is_space) begin
                     if (has_text_ff) begin
                        state_in = cst_pkg::ST_TRAIL;
                     end
                  end else if (cc == cst_pkg::CC_COMMA) begin
                     comma_go = 1'b1;
                  end else if (cc == cst_pkg::CC_CLOSE) begin
                     if (!has_text_ff) begin
                        err = cst_pkg::PS_EMPTY_ARG;
                     end else begin
                        rsp_item.byte_role = cst_pkg::ROLE_SEP;
                        argn_sel           = 1'b1;
                        arg_cnt_in         = cnt_plus;
                        fin                = 1'b1;
                     end
                  end else begin
                     rsp_item.byte_role = cst_pkg::ROLE_ARG;
                     argn_sel           = 1'b1;
                     has_text_in        = 1'b1;
                  end
               end
               cst_pkg::ST_TRAIL: begin
                  if (cc == cst_pkg::CC_COMMA) begin
                     state_in = cst_pkg::ST_ARG;
                     comma_go = 1'b1;
                  end else if (!is_space) begin
                     err = cst_pkg::PS_INNER_SPACE;
                  end
               end
               default: begin
               end
            endcase

            // opening bracket or a line without one
            if (open_go) begin
               if (cc == cst_pkg::CC_OPEN) begin
                  rsp_item.byte_role = cst_pkg::ROLE_SEP;
                  has_text_in        = 1'b0;
                  arg_cnt_in         = '0;
                  state_in           = cst_pkg::ST_ARG;
               end else begin
                  fin = 1'b1;
               end
            end

            // argument separator
            if (comma_go) begin
               if (!has_text_ff) begin
                  err = cst_pkg::PS_EMPTY_ARG;
               end else begin
                  rsp_item.byte_role = cst_pkg::ROLE_SEP;
                  argn_sel           = 1'b1;
                  arg_cnt_in         = cnt_plus;
                  has_text_in        = 1'b0;
                  if (cnt_plus >= CNT_W'(MAX_ARGS)) begin
                     err = cst_pkg::PS_TOO_MANY;
                  end
               end
            end
         end

         if (argn_sel) begin
            rsp_item.arg_number = cnt_ext[2:0];
         end

         // finish reporting
         if (err != cst_pkg::PS_OK) begin
            rsp_item.byte_role    = cst_pkg::ROLE_SKIP;
            rsp_item.arg_number   = '0;
            rsp_item.line_done    = 1'b1;
            rsp_item.parse_status = err;
            fin                   = 1'b1;
         end else if (fin) begin
            rsp_item.line_done  = 1'b1;
            rsp_item.args_found = found_ext[3:0];
         end

         if (fin) begin
            if (is_zero) begin
               new_line = 1'b1;
            end else begin
               state_in = cst_pkg::ST_DRAIN;
            end
         end else begin
            pos_in        = pos_ff + POS_W'(1);
            line_start_in = 1'b0;
         end
      end

      // fresh line
      if (new_line) begin
         state_in      = cst_pkg::ST_LEAD;
         has_text_in   = 1'b0;
         arg_cnt_in    = '0;
         pos_in        = '0;
         line_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cst_pkg::ST_LEAD;
         has_text_ff   <= 1'b0;
         arg_cnt_ff    <= '0;
         pos_ff        <= '0;
         line_start_ff <= 1'b1;
      end else if (cls_pop) begin
         state_ff      <= state_in;
         has_text_ff   <= has_text_in;
         arg_cnt_ff    <= arg_cnt_in;
         pos_ff        <= pos_in;
         line_start_ff <= line_start_in;
      end
   end

endmodule
